// File: hw/rtl/iate_pkg.sv
// ----------------------------------------------------------------------------
// iate_pkg
// Shared types and codes for the indexed array table engine: item fields,
// action and status codes, controller states and the controller/datapath
// command and flag bundles.
// ----------------------------------------------------------------------------
package iate_pkg;

   typedef logic [2:0]  action_type;
   typedef logic [6:0]  pos_type;
   typedef logic [6:0]  len_type;
   typedef logic [31:0] value_type;
   typedef logic [5:0]  found_type;
   typedef logic [6:0]  count_type;

   localparam action_type ACT_APPEND     = 3'd0;
   localparam action_type ACT_INSERT     = 3'd1;
   localparam action_type ACT_SET        = 3'd2;
   localparam action_type ACT_GET        = 3'd3;
   localparam action_type ACT_REMOVE_RUN = 3'd4;
   localparam action_type ACT_FIND       = 3'd5;
   localparam action_type ACT_REMOVE_VAL = 3'd6;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_ABSENT = 2'd3
   } status_type;

   // read port address source; every read also moves the source pointer
   typedef enum logic [2:0] {
      RD_NONE,
      RD_POS,
      RD_CNT_M1,
      RD_POS_LEN,
      RD_ZERO,
      RD_SRC_DEC,
      RD_SRC_INC
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CNT_VAL,
      WR_POS_VAL,
      WR_UP,
      WR_DN
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_SUB_LEN
   } cnt_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_GET,
      S_SHIFT_UP,
      S_INS_WRITE,
      S_SHIFT_DN,
      S_SCAN,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic       load_item;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       len_one;
      logic       res_load;
      status_type res_status;
      logic       res_read;
      logic       res_found;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      action_type act;
      logic       full;
      logic       pos_gt_cnt;
      logic       pos_ge_cnt;
      logic       run_bad;
      logic       len_zero;
      logic       run_at_end;
      logic       ins_at_end;
      logic       cnt_zero;
      logic       match;
      logic       src_is_pos;
      logic       src_is_last;
      logic       out_free;
   } dp_flags_type;

endpackage

// File: hw/rtl/iate_channels.sv
// ----------------------------------------------------------------------------
// iate channels
// Valid/ready channel interfaces for request items and response items.
// ----------------------------------------------------------------------------
interface iate_req_if;
   logic                  valid;
   logic                  ready;
   iate_pkg::action_type  action;
   iate_pkg::pos_type     position;
   iate_pkg::len_type     run_length;
   iate_pkg::value_type   element_value;

   modport source (output valid, action, position, run_length, element_value,
                   input ready);
   modport sink   (input valid, action, position, run_length, element_value,
                   output ready);
endinterface

interface iate_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   iate_pkg::value_type   read_value;
   iate_pkg::found_type   found_index;
   iate_pkg::count_type   live_count;

   modport source (output valid, status, read_value, found_index, live_count,
                   input ready);
   modport sink   (input valid, status, read_value, found_index, live_count,
                   output ready);
endinterface

// File: hw/rtl/indexed_array_table_engine.sv
// ----------------------------------------------------------------------------
// indexed_array_table_engine
// Packed element array with live count: append, insert, set, get, remove
// run, find and remove value, one response item per request item.
// ----------------------------------------------------------------------------
// One request item is handled at a time. The element memory has a single
// write port and a registered read port, so shifts and searches move one
// entry per cycle. Append, set, failed checks and unused actions finish in
// the check state; get adds one read; insert shifts the entries from the
// position up by one, then writes; remove run shifts the tail down by the
// run length; find reads up from entry zero to a match or the last entry;
// remove value then shifts the tail down by one. A new item can be taken
// in the cycle after the response register is loaded, while the previous
// response may still wait to be taken. The element memory is not cleared
// by reset; only entries below the count are ever read.
module indexed_array_table_engine #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   iate_req_if.sink   req_chan,
   iate_rsp_if.source rsp_chan
);

   iate_pkg::dp_cmd_type   cmd;
   iate_pkg::dp_flags_type flags;

   iate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   iate_datapath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_action        (req_chan.action),
      .req_position      (req_chan.position),
      .req_run_length    (req_chan.run_length),
      .req_element_value (req_chan.element_value),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_read_value    (rsp_chan.read_value),
      .rsp_found_index   (rsp_chan.found_index),
      .rsp_live_count    (rsp_chan.live_count)
   );

endmodule

// File: hw/rtl/iate_datapath.sv
// ----------------------------------------------------------------------------
// iate_datapath
// Element memory, live count, walk pointer, result and output registers.
// Driven by the controller through a command bundle, reports flags back.
// ----------------------------------------------------------------------------
module iate_datapath #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  iate_pkg::dp_cmd_type   cmd,
   output iate_pkg::dp_flags_type flags,
   input  iate_pkg::action_type   req_action,
   input  iate_pkg::pos_type      req_position,
   input  iate_pkg::len_type      req_run_length,
   input  iate_pkg::value_type    req_element_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output iate_pkg::value_type    rsp_read_value,
   output iate_pkg::found_type    rsp_found_index,
   output iate_pkg::count_type    rsp_live_count
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

   logic [ELEM_WIDTH-1:0] mem [CAPACITY];

   iate_pkg::action_type  act_ff;
   iate_pkg::pos_type     pos_ff;
   iate_pkg::len_type     len_ff;
   logic [ELEM_WIDTH-1:0] key_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         src_ff;
   logic [ELEM_WIDTH-1:0] rdata_ff;

   iate_pkg::status_type  res_status_ff;
   iate_pkg::value_type   res_read_ff;
   iate_pkg::found_type   res_found_ff;

   logic                  out_valid_ff, out_valid_in;
   iate_pkg::status_type  out_status_ff;
   iate_pkg::value_type   out_read_ff;
   iate_pkg::found_type   out_found_ff;
   iate_pkg::count_type   out_count_ff;

   logic [CMPW-1:0]       pos_ext, len_ext, cnt_ext, end_ext, src_ext;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;

   assign pos_ext = CMPW'(pos_ff);
   assign len_ext = CMPW'(len_ff);
   assign cnt_ext = CMPW'(cnt_ff);
   assign end_ext = pos_ext + len_ext;
   assign src_ext = CMPW'(src_ff);

   always_comb begin
      flags.act         = act_ff;
      flags.full        = (cnt_ext == CMPW'(CAPACITY));
      flags.pos_gt_cnt  = (pos_ext > cnt_ext);
      flags.pos_ge_cnt  = (pos_ext >= cnt_ext);
      flags.run_bad     = (end_ext > cnt_ext);
      flags.len_zero    = (len_ff == '0);
      flags.run_at_end  = (end_ext == cnt_ext);
      flags.ins_at_end  = (pos_ext == cnt_ext);
      flags.cnt_zero    = (cnt_ff == '0);
      flags.match       = (rdata_ff == key_ff);
      flags.src_is_pos  = (src_ext == pos_ext);
      flags.src_is_last = ((src_ext + CMPW'(1)) == cnt_ext);
      flags.out_free    = ~out_valid_ff | rsp_ready;
   end

   always_comb begin
      rd_en = (cmd.rd_sel != iate_pkg::RD_NONE);
      case (cmd.rd_sel)
         iate_pkg::RD_POS:     rd_addr = AW'(pos_ext);
         iate_pkg::RD_CNT_M1:  rd_addr = AW'(cnt_ext - CMPW'(1));
         iate_pkg::RD_POS_LEN: rd_addr = AW'(end_ext);
         iate_pkg::RD_SRC_DEC: rd_addr = src_ff - AW'(1);
         iate_pkg::RD_SRC_INC: rd_addr = src_ff + AW'(1);
         default:              rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en = (cmd.wr_sel != iate_pkg::WR_NONE);
      case (cmd.wr_sel)
         iate_pkg::WR_CNT_VAL: begin
            wr_addr = AW'(cnt_ext);
            wr_data = key_ff;
         end
         iate_pkg::WR_POS_VAL: begin
            wr_addr = AW'(pos_ext);
            wr_data = key_ff;
         end
         iate_pkg::WR_UP: begin
            wr_addr = src_ff + AW'(1);
            wr_data = rdata_ff;
         end
         iate_pkg::WR_DN: begin
            wr_addr = AW'(src_ext - len_ext);
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = '0;
         end
      endcase
   end

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         src_ff   <= rd_addr;
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         iate_pkg::CNT_INC:     cnt_in = cnt_ff + CW'(1);
         iate_pkg::CNT_DEC:     cnt_in = cnt_ff - CW'(1);
         iate_pkg::CNT_SUB_LEN: cnt_in = CW'(cnt_ext - len_ext);
         default:               cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff <= req_action;
         pos_ff <= req_position;
         key_ff <= ELEM_WIDTH'(req_element_value);
      end
      if (cmd.load_item) begin
         len_ff <= req_run_length;
      end else if (cmd.len_one) begin
         len_ff <= iate_pkg::len_type'(1);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_read_ff   <= cmd.res_read ? iate_pkg::value_type'(rdata_ff) : '0;
         res_found_ff  <= cmd.res_found ? iate_pkg::found_type'(src_ff) : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_read_ff   <= res_read_ff;
         out_found_ff  <= res_found_ff;
         out_count_ff  <= iate_pkg::count_type'(cnt_ff);
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_read_value  = out_read_ff;
   assign rsp_found_index = out_found_ff;
   assign rsp_live_count  = out_count_ff;

endmodule

// File: hw/rtl/iate_ctrl.sv
// ----------------------------------------------------------------------------
// iate_ctrl
// Request sequencer: checks the item against the count, then walks the
// element memory one entry a cycle for shifts and searches.
// ----------------------------------------------------------------------------
module iate_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iate_pkg::dp_flags_type flags,
   output iate_pkg::dp_cmd_type   cmd
);

   iate_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iate_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iate_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = iate_pkg::S_CHECK;
            end
         end
         iate_pkg::S_CHECK: begin
            state_in = iate_pkg::S_RESPOND;
            case (flags.act)
               iate_pkg::ACT_INSERT: begin
                  if (!flags.pos_gt_cnt && !flags.full && !flags.ins_at_end) begin
                     state_in = iate_pkg::S_SHIFT_UP;
                  end
               end
               iate_pkg::ACT_GET: begin
                  if (!flags.pos_ge_cnt) begin
                     state_in = iate_pkg::S_GET;
                  end
               end
               iate_pkg::ACT_REMOVE_RUN: begin
                  if (!flags.pos_ge_cnt && !flags.run_bad && !flags.len_zero &&
                      !flags.run_at_end) begin
                     state_in = iate_pkg::S_SHIFT_DN;
                  end
               end
               iate_pkg::ACT_FIND, iate_pkg::ACT_REMOVE_VAL: begin
                  if (!flags.cnt_zero) begin
                     state_in = iate_pkg::S_SCAN;
                  end
               end
               default: state_in = iate_pkg::S_RESPOND;
            endcase
         end
         iate_pkg::S_GET: state_in = iate_pkg::S_RESPOND;
         iate_pkg::S_SHIFT_UP: begin
            if (flags.src_is_pos) begin
               state_in = iate_pkg::S_INS_WRITE;
            end
         end
         iate_pkg::S_INS_WRITE: state_in = iate_pkg::S_RESPOND;
         iate_pkg::S_SHIFT_DN: begin
            if (flags.src_is_last) begin
               state_in = iate_pkg::S_RESPOND;
            end
         end
         iate_pkg::S_SCAN: begin
            if (flags.match) begin
               if (flags.act == iate_pkg::ACT_REMOVE_VAL && !flags.src_is_last) begin
                  state_in = iate_pkg::S_SHIFT_DN;
               end else begin
                  state_in = iate_pkg::S_RESPOND;
               end
            end else if (flags.src_is_last) begin
               state_in = iate_pkg::S_RESPOND;
            end
         end
         iate_pkg::S_RESPOND: begin
            if (flags.out_free) begin
               state_in = iate_pkg::S_IDLE;
            end
         end
         default: state_in = iate_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         iate_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         iate_pkg::S_CHECK: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = iate_pkg::STAT_OK;
            case (flags.act)
               iate_pkg::ACT_APPEND: begin
                  if (flags.full) begin
                     cmd.res_status = iate_pkg::STAT_FULL;
                  end else begin
                     cmd.wr_sel = iate_pkg::WR_CNT_VAL;
                     cmd.cnt_op = iate_pkg::CNT_INC;
                  end
               end
               iate_pkg::ACT_INSERT: begin
                  if (flags.pos_gt_cnt) begin
                     cmd.res_status = iate_pkg::STAT_RANGE;
                  end else if (flags.full) begin
                     cmd.res_status = iate_pkg::STAT_FULL;
                  end else if (flags.ins_at_end) begin
                     cmd.wr_sel = iate_pkg::WR_POS_VAL;
                     cmd.cnt_op = iate_pkg::CNT_INC;
                  end else begin
                     cmd.rd_sel = iate_pkg::RD_CNT_M1;
                  end
               end
               iate_pkg::ACT_SET: begin
                  if (flags.pos_ge_cnt) begin
                     cmd.res_status = iate_pkg::STAT_RANGE;
                  end else begin
                     cmd.wr_sel = iate_pkg::WR_POS_VAL;
                  end
               end
               iate_pkg::ACT_GET: begin
                  if (flags.pos_ge_cnt) begin
                     cmd.res_status = iate_pkg::STAT_RANGE;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd_sel   = iate_pkg::RD_POS;
                  end
               end
               iate_pkg::ACT_REMOVE_RUN: begin
                  if (flags.pos_ge_cnt || flags.run_bad) begin
                     cmd.res_status = iate_pkg::STAT_RANGE;
                  end else if (flags.len_zero || flags.run_at_end) begin
                     cmd.cnt_op = iate_pkg::CNT_SUB_LEN;
                  end else begin
                     cmd.rd_sel = iate_pkg::RD_POS_LEN;
                  end
               end
               iate_pkg::ACT_FIND, iate_pkg::ACT_REMOVE_VAL: begin
                  if (flags.cnt_zero) begin
                     cmd.res_status = iate_pkg::STAT_ABSENT;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd_sel   = iate_pkg::RD_ZERO;
                  end
               end
               default: cmd.res_status = iate_pkg::STAT_OK;
            endcase
         end
         iate_pkg::S_GET: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = iate_pkg::STAT_OK;
            cmd.res_read   = 1'b1;
         end
         iate_pkg::S_SHIFT_UP: begin
            cmd.wr_sel = iate_pkg::WR_UP;
            if (!flags.src_is_pos) begin
               cmd.rd_sel = iate_pkg::RD_SRC_DEC;
            end
         end
         iate_pkg::S_INS_WRITE: begin
            cmd.wr_sel = iate_pkg::WR_POS_VAL;
            cmd.cnt_op = iate_pkg::CNT_INC;
         end
         iate_pkg::S_SHIFT_DN: begin
            cmd.wr_sel = iate_pkg::WR_DN;
            if (flags.src_is_last) begin
               cmd.cnt_op = iate_pkg::CNT_SUB_LEN;
            end else begin
               cmd.rd_sel = iate_pkg::RD_SRC_INC;
            end
         end
         iate_pkg::S_SCAN: begin
            if (flags.match) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = iate_pkg::STAT_OK;
               cmd.res_found  = 1'b1;
               if (flags.act == iate_pkg::ACT_REMOVE_VAL) begin
                  if (flags.src_is_last) begin
                     cmd.cnt_op = iate_pkg::CNT_DEC;
                  end else begin
                     // close the gap: tail moves down by one
                     cmd.rd_sel  = iate_pkg::RD_SRC_INC;
                     cmd.len_one = 1'b1;
                  end
               end
            end else if (flags.src_is_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = iate_pkg::STAT_ABSENT;
            end else begin
               cmd.rd_sel = iate_pkg::RD_SRC_INC;
            end
         end
         iate_pkg::S_RESPOND: begin
            cmd.out_load = flags.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule
